FILE: rtl/core/swhf_pkg.sv
// ----------------------------------------------------------------------------
// swhf_pkg
// Shared types and constants for the spherical wall haptic force core.
// ----------------------------------------------------------------------------
package swhf_pkg;

   localparam int unsigned CoordW  = 32;
   localparam int unsigned MagW    = 31;
   localparam int unsigned AddrW   = 5;
   localparam int unsigned RootW   = 31;
   localparam int unsigned RadW    = 2 * RootW;
   localparam int unsigned NumW    = 2 * MagW;

   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_RADIUS   = 3'd3;
   localparam logic [2:0] REG_GAIN     = 3'd4;
   localparam logic [2:0] REG_LIMIT    = 3'd5;

   typedef struct packed {
      logic       outside;
      logic       surface;
      logic [2:0] neg;
   } tag_type;

endpackage

FILE: rtl/core/spherical_wall_haptic_force_core.sv
// ----------------------------------------------------------------------------
// spherical_wall_haptic_force_core
// Spring force of a spherical virtual wall: offset, exact inside test,
// bit-per-stage square root, spring magnitude, bit-per-stage divide.
// Throughput: one request per cycle; busy is never raised.
// Depth is set by the 31-stage root and 31-stage divider pipelines.
// Synchronous reset clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module spherical_wall_haptic_force_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_pos_x,
   input  logic signed [31:0]          req_pos_y,
   input  logic signed [31:0]          req_pos_z,
   output logic                        rsp_valid,
   output logic signed [31:0]          rsp_force_x,
   output logic signed [31:0]          rsp_force_y,
   output logic signed [31:0]          rsp_force_z,
   output logic                        rsp_in_contact,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [swhf_pkg::AddrW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int unsigned RW = swhf_pkg::RootW;
   localparam int unsigned MW = swhf_pkg::MagW;

   // configuration
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        radius_ff, gain_ff, limit_ff;
   logic               wr_en;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         cz_ff     <= '0;
         radius_ff <= '0;
         gain_ff   <= '0;
         limit_ff  <= '0;
      end else if (wr_en) begin
         case (paddr[4:2])
            swhf_pkg::REG_CENTER_X: cx_ff     <= pwdata;
            swhf_pkg::REG_CENTER_Y: cy_ff     <= pwdata;
            swhf_pkg::REG_CENTER_Z: cz_ff     <= pwdata;
            swhf_pkg::REG_RADIUS:   radius_ff <= pwdata[30:0];
            swhf_pkg::REG_GAIN:     gain_ff   <= pwdata[30:0];
            swhf_pkg::REG_LIMIT:    limit_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         swhf_pkg::REG_CENTER_X: prdata = cx_ff;
         swhf_pkg::REG_CENTER_Y: prdata = cy_ff;
         swhf_pkg::REG_CENTER_Z: prdata = cz_ff;
         swhf_pkg::REG_RADIUS:   prdata = {1'b0, radius_ff};
         swhf_pkg::REG_GAIN:     prdata = {1'b0, gain_ff};
         swhf_pkg::REG_LIMIT:    prdata = {1'b0, limit_ff};
         default:                prdata = '0;
      endcase
   end

   // stage 0: capture request
   logic               v0_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start & ~busy;
      px_ff <= req_pos_x;
      py_ff <= req_pos_y;
      pz_ff <= req_pos_z;
   end

   // stage 1: offsets and magnitudes
   logic signed [32:0] dx_in, dy_in, dz_in;
   logic [32:0]        ax1_ff, ay1_ff, az1_ff;
   logic [2:0]         neg1_ff;
   logic               v1_ff;

   assign dx_in = 33'(signed'({px_ff[31], px_ff}) - signed'({cx_ff[31], cx_ff}));
   assign dy_in = 33'(signed'({py_ff[31], py_ff}) - signed'({cy_ff[31], cy_ff}));
   assign dz_in = 33'(signed'({pz_ff[31], pz_ff}) - signed'({cz_ff[31], cz_ff}));

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      ax1_ff  <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
      ay1_ff  <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
      az1_ff  <= dz_in[32] ? 33'(-dz_in) : 33'(dz_in);
      neg1_ff <= {dz_in[32], dy_in[32], dx_in[32]};
   end

   // stage 2: squares
   logic [65:0]      sx2_ff, sy2_ff, sz2_ff;
   logic [61:0]      rsq2_ff;
   logic [RW-1:0]    ax2_ff, ay2_ff, az2_ff;
   logic [2:0]       neg2_ff;
   logic             v2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      sx2_ff  <= ax1_ff * ax1_ff;
      sy2_ff  <= ay1_ff * ay1_ff;
      sz2_ff  <= az1_ff * az1_ff;
      rsq2_ff <= radius_ff * radius_ff;
      ax2_ff  <= ax1_ff[RW-1:0];
      ay2_ff  <= ay1_ff[RW-1:0];
      az2_ff  <= az1_ff[RW-1:0];
      neg2_ff <= neg1_ff;
   end

   // stage 3: sum and compare into root pipeline entry
   logic [67:0] sum_in;
   assign sum_in = 68'(sx2_ff) + 68'(sy2_ff) + 68'(sz2_ff);

   logic                     rv_ff   [0:RW];
   swhf_pkg::tag_type        rtag_ff [0:RW];
   logic [RW-1:0]            rax_ff  [0:RW];
   logic [RW-1:0]            ray_ff  [0:RW];
   logic [RW-1:0]            raz_ff  [0:RW];
   logic [swhf_pkg::RadW-1:0] rad_ff [0:RW];
   logic [31:0]              rrem_ff [0:RW];
   logic [RW-1:0]            rroot_ff[0:RW];

   always_ff @(posedge clock) begin
      if (reset) rv_ff[0] <= 1'b0;
      else       rv_ff[0] <= v2_ff;
      rtag_ff[0].outside <= sum_in > 68'(rsq2_ff);
      rtag_ff[0].surface <= sum_in == 68'(rsq2_ff);
      rtag_ff[0].neg     <= neg2_ff;
      rax_ff[0]   <= ax2_ff;
      ray_ff[0]   <= ay2_ff;
      raz_ff[0]   <= az2_ff;
      rad_ff[0]   <= sum_in[swhf_pkg::RadW-1:0];
      rrem_ff[0]  <= '0;
      rroot_ff[0] <= '0;
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < RW; k++) begin : g_root
      localparam int unsigned B = RW - 1 - k;
      logic [33:0] tmp, trial;
      logic        take;
      assign tmp   = {rrem_ff[k], rad_ff[k][2*B+1:2*B]};
      assign trial = {1'b0, rroot_ff[k], 2'b01};
      assign take  = tmp >= trial;

      always_ff @(posedge clock) begin
         if (reset) rv_ff[k+1] <= 1'b0;
         else       rv_ff[k+1] <= rv_ff[k];
         rtag_ff[k+1]  <= rtag_ff[k];
         rax_ff[k+1]   <= rax_ff[k];
         ray_ff[k+1]   <= ray_ff[k];
         raz_ff[k+1]   <= raz_ff[k];
         rad_ff[k+1]   <= rad_ff[k];
         rrem_ff[k+1]  <= take ? 32'(tmp - trial) : tmp[31:0];
         rroot_ff[k+1] <= {rroot_ff[k][RW-2:0], take};
      end
   end

   // m1: penetration times gain
   logic              m1v_ff, m2v_ff, m3v_ff;
   swhf_pkg::tag_type m1tag_ff, m2tag_ff, m3tag_ff;
   logic [RW-1:0]     m1len_ff, m2len_ff, m3len_ff;
   logic [RW-1:0]     m1ax_ff, m1ay_ff, m1az_ff, m2ax_ff, m2ay_ff, m2az_ff;
   logic [61:0]       m1prod_ff;
   logic [MW-1:0]     m2mag_ff;
   logic [swhf_pkg::NumW-1:0] m3nx_ff, m3ny_ff, m3nz_ff;
   logic [30:0]       pen_in;

   assign pen_in = radius_ff - rroot_ff[RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1v_ff <= 1'b0;
         m2v_ff <= 1'b0;
         m3v_ff <= 1'b0;
      end else begin
         m1v_ff <= rv_ff[RW];
         m2v_ff <= m1v_ff;
         m3v_ff <= m2v_ff;
      end
      m1tag_ff  <= rtag_ff[RW];
      m1len_ff  <= rroot_ff[RW];
      m1ax_ff   <= rax_ff[RW];
      m1ay_ff   <= ray_ff[RW];
      m1az_ff   <= raz_ff[RW];
      m1prod_ff <= gain_ff * pen_in;

      m2tag_ff  <= m1tag_ff;
      m2len_ff  <= m1len_ff;
      m2ax_ff   <= m1ax_ff;
      m2ay_ff   <= m1ay_ff;
      m2az_ff   <= m1az_ff;
      m2mag_ff  <= (m1prod_ff[61:16] > 46'(limit_ff)) ? limit_ff : m1prod_ff[46:16];

      m3tag_ff  <= m2tag_ff;
      m3len_ff  <= m2len_ff;
      m3nx_ff   <= m2ax_ff * m2mag_ff;
      m3ny_ff   <= m2ay_ff * m2mag_ff;
      m3nz_ff   <= m2az_ff * m2mag_ff;
   end

   // divider, one quotient bit per stage, three lanes
   logic              dv_ff   [0:MW];
   swhf_pkg::tag_type dtag_ff [0:MW];
   logic [RW-1:0]     dlen_ff [0:MW];
   logic [MW-1:0]     dnum_ff [0:MW][3];
   logic [RW-1:0]     drem_ff [0:MW][3];
   logic [MW-1:0]     dq_ff   [0:MW][3];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= m3v_ff;
      dtag_ff[0]    <= m3tag_ff;
      dlen_ff[0]    <= m3len_ff;
      dnum_ff[0][0] <= m3nx_ff[MW-1:0];
      dnum_ff[0][1] <= m3ny_ff[MW-1:0];
      dnum_ff[0][2] <= m3nz_ff[MW-1:0];
      drem_ff[0][0] <= m3nx_ff[swhf_pkg::NumW-1:MW];
      drem_ff[0][1] <= m3ny_ff[swhf_pkg::NumW-1:MW];
      drem_ff[0][2] <= m3nz_ff[swhf_pkg::NumW-1:MW];
      dq_ff[0][0]   <= '0;
      dq_ff[0][1]   <= '0;
      dq_ff[0][2]   <= '0;
   end

   for (genvar j = 0; j < MW; j++) begin : g_div
      localparam int unsigned B = MW - 1 - j;
      always_ff @(posedge clock) begin
         if (reset) dv_ff[j+1] <= 1'b0;
         else       dv_ff[j+1] <= dv_ff[j];
         dtag_ff[j+1] <= dtag_ff[j];
         dlen_ff[j+1] <= dlen_ff[j];
      end
      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [RW:0] tmp;
         logic        take;
         assign tmp  = {drem_ff[j][l], dnum_ff[j][l][B]};
         assign take = tmp >= {1'b0, dlen_ff[j]};
         always_ff @(posedge clock) begin
            dnum_ff[j+1][l] <= dnum_ff[j][l];
            drem_ff[j+1][l] <= take ? RW'(tmp - {1'b0, dlen_ff[j]}) : tmp[RW-1:0];
            dq_ff[j+1][l]   <= {dq_ff[j][l][MW-2:0], take};
         end
      end
   end

   // output register
   logic        zero_out;
   logic [31:0] fx_in, fy_in, fz_in;

   assign zero_out = dtag_ff[MW].outside | (dlen_ff[MW] == '0);
   assign fx_in = dtag_ff[MW].neg[0] ? 32'(-{1'b0, dq_ff[MW][0]}) : {1'b0, dq_ff[MW][0]};
   assign fy_in = dtag_ff[MW].neg[1] ? 32'(-{1'b0, dq_ff[MW][1]}) : {1'b0, dq_ff[MW][1]};
   assign fz_in = dtag_ff[MW].neg[2] ? 32'(-{1'b0, dq_ff[MW][2]}) : {1'b0, dq_ff[MW][2]};

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= dv_ff[MW] & ~dtag_ff[MW].surface;
      rsp_force_x    <= zero_out ? '0 : fx_in;
      rsp_force_y    <= zero_out ? '0 : fy_in;
      rsp_force_z    <= zero_out ? '0 : fz_in;
      rsp_in_contact <= ~dtag_ff[MW].outside;
   end

endmodule

FILE: rtl/core/swhf_checker.sv
// ----------------------------------------------------------------------------
// swhf_checker
// Port-level checks for the spherical wall haptic force core.
// ----------------------------------------------------------------------------
module swhf_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_force_x,
   input logic signed [31:0] rsp_force_y,
   input logic signed [31:0] rsp_force_z,
   input logic               rsp_in_contact
);

   // edges from the request edge to the edge that takes the result
   localparam int unsigned Latency = 71;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_contact |->
         rsp_force_x == 0 && rsp_force_y == 0 && rsp_force_z == 0)
      else $error("nonzero force outside sphere");

   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without request");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind spherical_wall_haptic_force_core swhf_checker u_swhf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_force_x    (rsp_force_x),
   .rsp_force_y    (rsp_force_y),
   .rsp_force_z    (rsp_force_z),
   .rsp_in_contact (rsp_in_contact)
);
